@@ hw/rtl/dps_pkg.sv @@
// Package for the display power sequencer: codes, widths, state types and
// the delay load helper. No dependencies.
`default_nettype none

package dps_pkg;

   localparam int DELAY_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int SAT_WIDTH   = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_UP   = 2'd1;
   localparam logic [1:0] OP_DOWN = 2'd2;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [1:0] STG_PRE   = 2'd0;
   localparam logic [1:0] STG_WAIT1 = 2'd1;
   localparam logic [1:0] STG_WAIT2 = 2'd2;
   localparam logic [1:0] STG_DONE  = 2'd3;

   localparam logic [1:0] CSR_UP_RESET     = 2'd0;
   localparam logic [1:0] CSR_UP_STANDBY   = 2'd1;
   localparam logic [1:0] CSR_DOWN_LED     = 2'd2;
   localparam logic [1:0] CSR_DOWN_STANDBY = 2'd3;

   localparam logic [CFG_WIDTH-1:0] RST_UP_RESET     = CFG_WIDTH'(20);
   localparam logic [CFG_WIDTH-1:0] RST_UP_STANDBY   = CFG_WIDTH'(184);
   localparam logic [CFG_WIDTH-1:0] RST_DOWN_LED     = CFG_WIDTH'(1);
   localparam logic [CFG_WIDTH-1:0] RST_DOWN_STANDBY = CFG_WIDTH'(120);

   typedef struct packed {
      logic [CFG_WIDTH-1:0] up_reset;
      logic [CFG_WIDTH-1:0] up_standby;
      logic [CFG_WIDTH-1:0] down_led;
      logic [CFG_WIDTH-1:0] down_standby;
   } delays_type;

   typedef struct packed {
      logic [1:0]             direction;
      logic [1:0]             stage;
      logic [DELAY_WIDTH-1:0] delay;
      logic                   reset_out;
      logic                   standby_out;
      logic                   led_out;
   } seq_state_type;

   // saturate a register value into the delay counter
   function automatic logic [DELAY_WIDTH-1:0] delay_load(input logic [CFG_WIDTH-1:0] v);
      logic [SAT_WIDTH-1:0] wide;
      logic [SAT_WIDTH-1:0] top;
      wide = SAT_WIDTH'(v);
      top  = SAT_WIDTH'({DELAY_WIDTH{1'b1}});
      if (wide > top) begin
         return DELAY_WIDTH'(top);
      end
      return DELAY_WIDTH'(wide);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dps_step.sv @@
// Next-state logic of the power sequencer for one item.
// Depends on dps_pkg.
`default_nettype none

module dps_step
   import dps_pkg::*;
(
   input  wire logic [1:0]    op,
   input  wire logic          reset_level,
   input  wire logic          standby_level,
   input  wire logic          led_level,
   input  wire delays_type    delays,
   input  wire seq_state_type cur,
   output seq_state_type      nxt
);

   function automatic seq_state_type eval_up(input seq_state_type s, input logic rst,
                                             input logic stb, input delays_type d);
      seq_state_type r;
      r = s;
      if (r.stage == STG_WAIT1) begin
         if (rst && r.delay == '0) begin
            r.standby_out = 1'b1;
            r.delay       = delay_load(d.up_standby);
            r.stage       = STG_WAIT2;
         end
      end else if (r.stage == STG_WAIT2) begin
         if (stb && r.delay == '0) begin
            r.led_out = 1'b1;
            r.stage   = STG_DONE;
         end
      end
      return r;
   endfunction

   // power-down stages may chain within one item
   function automatic seq_state_type eval_down(input seq_state_type s, input logic rst,
                                               input logic stb, input logic led,
                                               input delays_type d);
      seq_state_type r;
      r = s;
      if (r.stage == STG_PRE && rst && stb && led) begin
         r.led_out = 1'b0;
         r.delay   = delay_load(d.down_led);
         r.stage   = STG_WAIT1;
      end
      if (r.stage == STG_WAIT1 && !led && r.delay == '0) begin
         r.standby_out = 1'b0;
         r.delay       = delay_load(d.down_standby);
         r.stage       = STG_WAIT2;
      end
      if (r.stage == STG_WAIT2 && !stb && r.delay == '0) begin
         r.reset_out = 1'b0;
         r.stage     = STG_DONE;
      end
      return r;
   endfunction

   always_comb begin
      seq_state_type s;
      s = cur;
      case (op)
         OP_TICK: begin
            if (s.delay != '0) begin
               s.delay = s.delay - 1'b1;
            end
            if (s.direction == DIR_UP) begin
               s = eval_up(s, reset_level, standby_level, delays);
            end else if (s.direction == DIR_DOWN) begin
               s = eval_down(s, reset_level, standby_level, led_level, delays);
            end
         end
         OP_UP: begin
            s.direction   = DIR_UP;
            s.reset_out   = 1'b1;
            s.standby_out = 1'b0;
            s.led_out     = 1'b0;
            s.delay       = delay_load(delays.up_reset);
            s.stage       = STG_WAIT1;
            s = eval_up(s, reset_level, standby_level, delays);
         end
         OP_DOWN: begin
            s.direction = DIR_DOWN;
            s.stage     = STG_PRE;
            s = eval_down(s, reset_level, standby_level, led_level, delays);
         end
         default: begin
         end
      endcase
      nxt = s;
   end

endmodule

`default_nettype wire

@@ hw/rtl/display_power_sequencer_core.sv @@
// Top level of the three-rail panel power sequencer.
// The result is registered: it becomes valid in the cycle after item acceptance.
// Throughput: one item per cycle while results are taken each cycle;
// the result register holds the sequencer state reported for the item.
// Reset (synchronous, active high) clears the sequence state and drives,
// and restores the delay registers to their defaults.
`default_nettype none

module display_power_sequencer_core
   import dps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_op,
   input  wire logic                 req_reset_level,
   input  wire logic                 req_standby_level,
   input  wire logic                 req_led_level,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_reset_drive,
   output logic                      rsp_standby_drive,
   output logic                      rsp_led_drive,
   output logic [1:0]                rsp_direction,
   output logic [1:0]                rsp_stage,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata
);

   seq_state_type state_ff, state_in;
   delays_type    delays_ff, delays_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   dps_step u_step (
      .op            (req_op),
      .reset_level   (req_reset_level),
      .standby_level (req_standby_level),
      .led_level     (req_led_level),
      .delays        (delays_ff),
      .cur           (state_ff),
      .nxt           (state_in)
   );

   always_comb begin
      delays_in = delays_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UP_RESET:     delays_in.up_reset     = csr_wdata;
            CSR_UP_STANDBY:   delays_in.up_standby   = csr_wdata;
            CSR_DOWN_LED:     delays_in.down_led     = csr_wdata;
            CSR_DOWN_STANDBY: delays_in.down_standby = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff               <= '0;
         delays_ff.up_reset     <= RST_UP_RESET;
         delays_ff.up_standby   <= RST_UP_STANDBY;
         delays_ff.down_led     <= RST_DOWN_LED;
         delays_ff.down_standby <= RST_DOWN_STANDBY;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         delays_ff    <= delays_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state only moves on acceptance, which needs the result slot empty or being taken
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reset_drive   = state_ff.reset_out;
   assign rsp_standby_drive = state_ff.standby_out;
   assign rsp_led_drive     = state_ff.led_out;
   assign rsp_direction     = state_ff.direction;
   assign rsp_stage         = state_ff.stage;

endmodule

`default_nettype wire
